FILE: rtl/aes128_block_cipher_macros.svh
// Assertion macros for the AES-128 block cipher.
// No dependencies; included by the top level.
`ifndef AES128_BLOCK_CIPHER_MACROS_SVH
`define AES128_BLOCK_CIPHER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define AES_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/aes_pkg.sv
// Shared types, codes and round functions for the AES-128 block cipher.
// No dependencies; used by aes128_block_cipher.
package aes_pkg;

   localparam int RK_ROWS = 11;
   localparam int RK_AW   = $clog2(RK_ROWS);
   localparam int CSR_IW  = 2;

   typedef enum logic [CSR_IW-1:0] {
      CSR_KEY_HIGH = 2'd0,
      CSR_KEY_LOW  = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_EXPAND,
      ST_IDLE,
      ST_INIT,
      ST_ROUND
   } state_type;

   typedef struct packed {
      logic        action;
      logic [63:0] data_high;
      logic [63:0] data_low;
   } req_type;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } rsp_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
   };

   function automatic logic [7:0] xtime(logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // inverse of the S-box affine map
   function automatic logic [7:0] inv_affine(logic [7:0] b);
      return {b[6:0], b[7]} ^ {b[4:0], b[7:5]} ^ {b[1:0], b[7:2]} ^ 8'h05;
   endfunction

   // inversion is an involution, so the forward table serves both ways
   function automatic logic [7:0] inv_sbox(logic [7:0] y);
      return inv_affine(SBOX[inv_affine(y)]);
   endfunction

   function automatic logic [127:0] sub_bytes(logic [127:0] s, logic inv);
      logic [127:0] t;
      for (int i = 0; i < 16; i++) begin
         t[127-8*i -: 8] = inv ? inv_sbox(s[127-8*i -: 8]) : SBOX[s[127-8*i -: 8]];
      end
      return t;
   endfunction

   function automatic logic [127:0] shift_rows(logic [127:0] s, logic inv);
      logic [127:0] t;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            if (inv) begin
               t[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c-r+4)%4)) -: 8];
            end else begin
               t[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c+r)%4)) -: 8];
            end
         end
      end
      return t;
   endfunction

   function automatic logic [31:0] mix_col(logic [31:0] col, logic inv);
      logic [7:0] a  [4];
      logic [7:0] m2 [4];
      logic [7:0] m4 [4];
      logic [7:0] m8 [4];
      logic [31:0] t;
      for (int r = 0; r < 4; r++) begin
         a[r]  = col[31-8*r -: 8];
         m2[r] = xtime(a[r]);
         m4[r] = xtime(m2[r]);
         m8[r] = xtime(m4[r]);
      end
      for (int r = 0; r < 4; r++) begin
         if (inv) begin
            t[31-8*r -: 8] = (m8[r] ^ m4[r] ^ m2[r])
                           ^ (m8[(r+1)%4] ^ m2[(r+1)%4] ^ a[(r+1)%4])
                           ^ (m8[(r+2)%4] ^ m4[(r+2)%4] ^ a[(r+2)%4])
                           ^ (m8[(r+3)%4] ^ a[(r+3)%4]);
         end else begin
            t[31-8*r -: 8] = m2[r] ^ (m2[(r+1)%4] ^ a[(r+1)%4])
                           ^ a[(r+2)%4] ^ a[(r+3)%4];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix_columns(logic [127:0] s, logic inv);
      logic [127:0] t;
      for (int c = 0; c < 4; c++) begin
         t[127-32*c -: 32] = mix_col(s[127-32*c -: 32], inv);
      end
      return t;
   endfunction

   // next four round-key words from the previous four
   function automatic logic [127:0] key_next(logic [127:0] rk, logic [7:0] rc);
      logic [31:0] w3;
      logic [31:0] t;
      logic [31:0] n0;
      logic [31:0] n1;
      logic [31:0] n2;
      logic [31:0] n3;
      w3 = rk[31:0];
      t  = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]}
         ^ {rc, 24'h000000};
      n0 = rk[127:96] ^ t;
      n1 = rk[95:64] ^ n0;
      n2 = rk[63:32] ^ n1;
      n3 = w3 ^ n2;
      return {n0, n1, n2, n3};
   endfunction

endpackage

FILE: rtl/aes_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the round keys of aes128_block_cipher.
module aes_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 11,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/aes128_block_cipher.sv
// AES-128 block cipher top level: key expansion sequencer and one shared round unit.
// Depends on aes_pkg, aes_ram and aes128_block_cipher_macros.svh.
//
// Channel   Ports                             Direction  Transaction
// request   start, busy, req_data             in         start & !busy
// response  rsp_valid, rsp_data               out        rsp_valid, one cycle
// config    csr_we, csr_index, csr_wdata      in         csr_we
//
// A block runs from accept to result as follows: the first round key is fetched at the
// accepting edge, then come the initial key addition, ten rounds through the single
// round unit and the result strobe; busy drops with the strobe.
// The round-key RAM (one 128-bit row per round) is rebuilt after reset and after each
// key write; busy is high meanwhile.
// Reset is synchronous; the receiver cannot stall, the result strobe lasts one cycle.
`include "aes128_block_cipher_macros.svh"

module aes128_block_cipher (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  aes_pkg::req_type             req_data,
   output logic                         rsp_valid,
   output aes_pkg::rsp_type             rsp_data,
   input  logic                         csr_we,
   input  logic [aes_pkg::CSR_IW-1:0]   csr_index,
   input  logic [63:0]                  csr_wdata
);

   localparam logic [aes_pkg::RK_AW-1:0] LAST = aes_pkg::RK_AW'(aes_pkg::RK_ROWS - 1);

   aes_pkg::state_type state_ff, state_in;
   logic [aes_pkg::RK_AW-1:0] cnt_ff, cnt_in;
   logic [63:0]  key_high_ff, key_high_in;
   logic [63:0]  key_low_ff, key_low_in;
   logic [127:0] rk_ff, rk_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic         act_ff, act_in;
   logic [127:0] blk_ff, blk_in;
   logic         rsp_valid_ff, rsp_valid_in;
   aes_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic         ram_we;
   logic [aes_pkg::RK_AW-1:0] ram_raddr;
   logic [127:0] ram_rdata;
   logic [127:0] enc_t;
   logic [127:0] dec_t;
   logic         key_wr;

   aes_ram #(
      .WIDTH(128),
      .DEPTH(aes_pkg::RK_ROWS)
   ) u_rk_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(cnt_ff),
      .wr_data(rk_ff),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aes_pkg::ST_EXPAND;
         cnt_ff       <= '0;
         key_high_ff  <= '0;
         key_low_ff   <= '0;
         rk_ff        <= '0;
         rcon_ff      <= 8'h01;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         key_high_ff  <= key_high_in;
         key_low_ff   <= key_low_in;
         rk_ff        <= rk_in;
         rcon_ff      <= rcon_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff      <= act_in;
      blk_ff      <= blk_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      enc_t = aes_pkg::shift_rows(aes_pkg::sub_bytes(blk_ff, 1'b0), 1'b0);
      if (cnt_ff != LAST) begin
         enc_t = aes_pkg::mix_columns(enc_t, 1'b0);
      end
      enc_t = enc_t ^ ram_rdata;
      dec_t = aes_pkg::sub_bytes(aes_pkg::shift_rows(blk_ff, 1'b1), 1'b1) ^ ram_rdata;
      if (cnt_ff != LAST) begin
         dec_t = aes_pkg::mix_columns(dec_t, 1'b1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      key_high_in  = key_high_ff;
      key_low_in   = key_low_ff;
      rk_in        = rk_ff;
      rcon_in      = rcon_ff;
      act_in       = act_ff;
      blk_in       = blk_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      key_wr       = 1'b0;
      busy         = (state_ff != aes_pkg::ST_IDLE);

      if (state_ff == aes_pkg::ST_IDLE) begin
         ram_raddr = req_data.action ? LAST : '0;
      end else if (act_ff) begin
         ram_raddr = aes_pkg::RK_AW'(LAST - 1'b1 - cnt_ff);
      end else begin
         ram_raddr = aes_pkg::RK_AW'(cnt_ff + 1'b1);
      end

      case (state_ff)
         aes_pkg::ST_EXPAND: begin
            ram_we  = 1'b1;
            rk_in   = aes_pkg::key_next(rk_ff, rcon_ff);
            rcon_in = aes_pkg::xtime(rcon_ff);
            cnt_in  = aes_pkg::RK_AW'(cnt_ff + 1'b1);
            if (cnt_ff == LAST) begin
               state_in = aes_pkg::ST_IDLE;
               cnt_in   = '0;
            end
         end
         aes_pkg::ST_IDLE: begin
            if (start) begin
               state_in = aes_pkg::ST_INIT;
               act_in   = req_data.action;
               blk_in   = {req_data.data_high, req_data.data_low};
               cnt_in   = '0;
            end
         end
         aes_pkg::ST_INIT: begin
            blk_in   = blk_ff ^ ram_rdata;
            cnt_in   = aes_pkg::RK_AW'(cnt_ff + 1'b1);
            state_in = aes_pkg::ST_ROUND;
         end
         aes_pkg::ST_ROUND: begin
            blk_in = act_ff ? dec_t : enc_t;
            cnt_in = aes_pkg::RK_AW'(cnt_ff + 1'b1);
            if (cnt_ff == LAST) begin
               state_in     = aes_pkg::ST_IDLE;
               cnt_in       = '0;
               rsp_valid_in = 1'b1;
               rsp_data_in  = act_ff ? dec_t : enc_t;
            end
         end
         default: begin
            state_in = aes_pkg::ST_EXPAND;
            cnt_in   = '0;
         end
      endcase

      // key write restarts the expansion from the new key
      if (csr_we) begin
         case (csr_index)
            aes_pkg::CSR_KEY_HIGH: begin
               key_high_in = csr_wdata;
               key_wr      = 1'b1;
            end
            aes_pkg::CSR_KEY_LOW: begin
               key_low_in = csr_wdata;
               key_wr     = 1'b1;
            end
            default: begin
               key_wr = 1'b0;
            end
         endcase
      end
      if (key_wr) begin
         state_in     = aes_pkg::ST_EXPAND;
         cnt_in       = '0;
         rcon_in      = 8'h01;
         rk_in        = {key_high_in, key_low_in};
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `AES_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy,
                    "accepted transaction did not raise busy")
   `AES_ASSERT_SAME(a_rsp_after_work, clock, reset, rsp_valid, $past(busy),
                    "response strobe without a transaction in flight")
   `AES_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid,
                    "response strobe lasted more than one cycle")

endmodule
